/* hdl/mtee_pkg.sv */
// Package for the MIDI track event encoder: tick width, command codes, byte constants,
// the event record passed from the front to the back, and the byte selection function.
// Depends on nothing; every other file of the block uses it.
package mtee_pkg;

  localparam int TICK_BITS = 28;
  localparam int VLQ_MAX   = (TICK_BITS + 6) / 7;
  localparam int VLQ_BITS  = VLQ_MAX * 7;
  localparam int IDX_BITS  = 3;
  localparam int ARG_BITS  = 24;

  typedef enum logic [1:0] {
    CMD_CHANNEL = 2'd0,
    CMD_TEMPO   = 2'd1,
    CMD_TIMESIG = 2'd2,
    CMD_END     = 2'd3
  } cmd_t;

  localparam logic [7:0] DELTA_ZERO     = 8'h00;
  localparam logic [7:0] META_PREFIX    = 8'hFF;
  localparam logic [7:0] META_TEMPO     = 8'h51;
  localparam logic [7:0] META_TIMESIG   = 8'h58;
  localparam logic [7:0] META_END       = 8'h2F;
  localparam logic [7:0] TEMPO_LEN      = 8'h03;
  localparam logic [7:0] TIMESIG_LEN    = 8'h04;
  localparam logic [7:0] END_LEN        = 8'h00;
  localparam logic [7:0] TIMESIG_DENOM  = 8'h02;
  localparam logic [7:0] TIMESIG_CLOCKS = 8'h18;
  localparam logic [7:0] TIMESIG_32NDS  = 8'h08;

  localparam logic [IDX_BITS-1:0] TEMPO_LAST   = 3'd6;
  localparam logic [IDX_BITS-1:0] TIMESIG_LAST = 3'd7;
  localparam logic [IDX_BITS-1:0] END_LAST     = 3'd3;

  // For a channel event arg holds {2'b0, status, data one, data two}; for a tempo
  // event the tempo value; for a time signature the numerator in its low byte.
  typedef struct packed {
    cmd_t                  cmd;
    logic                  err;
    logic [TICK_BITS-1:0]  delta;
    logic [IDX_BITS-1:0]   groups;
    logic [IDX_BITS-1:0]   last_idx;
    logic [ARG_BITS-1:0]   arg;
  } event_t;

  typedef struct packed {
    logic   valid;
    event_t ev;
  } head_t;

  function automatic logic [7:0] event_byte(event_t ev, logic [IDX_BITS-1:0] idx);
    logic [VLQ_BITS-1:0] ext;
    logic [IDX_BITS-1:0] grp;
    logic [7:0]          b;
    ext = VLQ_BITS'(ev.delta);
    grp = ev.groups - idx - 3'd1;
    b   = DELTA_ZERO;
    case (ev.cmd)
      CMD_CHANNEL: begin
        if (idx < ev.groups) begin
          for (int k = 0; k < VLQ_MAX; k++) begin
            if (grp == IDX_BITS'(k)) begin
              b = {(k != 0), ext[7*k +: 7]};
            end
          end
        end else if (idx == ev.groups) begin
          b = ev.arg[21:14];
        end else if (idx == ev.groups + 3'd1) begin
          b = {1'b0, ev.arg[13:7]};
        end else begin
          b = {1'b0, ev.arg[6:0]};
        end
      end
      CMD_TEMPO: begin
        case (idx)
          3'd0:    b = DELTA_ZERO;
          3'd1:    b = META_PREFIX;
          3'd2:    b = META_TEMPO;
          3'd3:    b = TEMPO_LEN;
          3'd4:    b = ev.arg[23:16];
          3'd5:    b = ev.arg[15:8];
          default: b = ev.arg[7:0];
        endcase
      end
      CMD_TIMESIG: begin
        case (idx)
          3'd0:    b = DELTA_ZERO;
          3'd1:    b = META_PREFIX;
          3'd2:    b = META_TIMESIG;
          3'd3:    b = TIMESIG_LEN;
          3'd4:    b = ev.arg[7:0];
          3'd5:    b = TIMESIG_DENOM;
          3'd6:    b = TIMESIG_CLOCKS;
          default: b = TIMESIG_32NDS;
        endcase
      end
      default: begin
        case (idx)
          3'd0:    b = DELTA_ZERO;
          3'd1:    b = META_PREFIX;
          3'd2:    b = META_END;
          default: b = END_LEN;
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

/* hdl/mtee_front.sv */
// Front end of the MIDI track event encoder: holds the previous tick, works out the
// delta and its VLQ length, and builds the event record. Depends on mtee_pkg.
module mtee_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [1:0]                    command,
  input  logic [mtee_pkg::TICK_BITS-1:0] tick,
  input  logic [7:0]                    status_byte,
  input  logic [6:0]                    data_one,
  input  logic [6:0]                    data_two,
  input  logic [23:0]                   micros_per_quarter,
  input  logic [7:0]                    beats_per_bar,
  output mtee_pkg::event_t              ev
);

  logic [mtee_pkg::TICK_BITS-1:0] previous_tick_r;
  logic [mtee_pkg::TICK_BITS-1:0] previous_tick_nxt;
  logic [mtee_pkg::TICK_BITS-1:0] delta;
  logic [mtee_pkg::VLQ_BITS-1:0]  delta_ext;
  logic                           late;
  logic                           is_channel;

  assign is_channel = (mtee_pkg::cmd_t'(command) == mtee_pkg::CMD_CHANNEL);
  assign previous_tick_nxt = (accept && is_channel) ? tick : previous_tick_r;
  assign late      = (tick < previous_tick_r);
  assign delta     = late ? '0 : tick - previous_tick_r;
  assign delta_ext = mtee_pkg::VLQ_BITS'(delta);

  always_comb begin
    ev.cmd      = mtee_pkg::cmd_t'(command);
    ev.err      = 1'b0;
    ev.delta    = '0;
    ev.groups   = 3'd1;
    ev.last_idx = mtee_pkg::END_LAST;
    ev.arg      = '0;
    case (mtee_pkg::cmd_t'(command))
      mtee_pkg::CMD_CHANNEL: begin
        ev.err   = late;
        ev.delta = delta;
        ev.arg   = {2'b00, status_byte, data_one, data_two};
      end
      mtee_pkg::CMD_TEMPO: begin
        ev.last_idx = mtee_pkg::TEMPO_LAST;
        ev.arg      = micros_per_quarter;
      end
      mtee_pkg::CMD_TIMESIG: begin
        ev.last_idx = mtee_pkg::TIMESIG_LAST;
        ev.arg      = {16'h0000, beats_per_bar};
      end
      default: begin
        ev.last_idx = mtee_pkg::END_LAST;
      end
    endcase
    if (is_channel) begin
      for (int g = 1; g < mtee_pkg::VLQ_MAX; g++) begin
        if ((delta_ext >> (7 * g)) != '0) begin
          ev.groups = mtee_pkg::IDX_BITS'(g + 1);
        end
      end
      ev.last_idx = ev.groups + 3'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      previous_tick_r <= '0;
    end else begin
      previous_tick_r <= previous_tick_nxt;
    end
  end

endmodule

/* hdl/mtee_queue.sv */
// Two-entry event queue between the front and the back of the MIDI track event
// encoder. Depends on mtee_pkg for the event record.
module mtee_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mtee_pkg::event_t push_ev,
  input  logic             pop,
  output mtee_pkg::head_t  head,
  output logic             full
);

  mtee_pkg::event_t mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;

  assign full       = (count_r == 2'd2);
  assign head.valid = (count_r != 2'd0);
  assign head.ev    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

/* hdl/mtee_back.sv */
// Back end of the MIDI track event encoder: walks the head event byte by byte into
// the output register. Depends on mtee_pkg for the event record and byte function.
module mtee_back (
  input  logic            clk,
  input  logic            rst_n,
  input  mtee_pkg::head_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last_byte,
  output logic            out_order_error
);

  logic                          out_valid_r;
  logic [7:0]                    out_byte_r;
  logic                          out_last_byte_r;
  logic                          out_order_error_r;
  logic [mtee_pkg::IDX_BITS-1:0] idx_r;
  logic [mtee_pkg::IDX_BITS-1:0] idx_nxt;
  logic                          advance;
  logic                          load;

  assign advance = !out_valid_r || !out_stall;
  assign load    = advance && head.valid;
  assign pop     = load && (idx_r == head.ev.last_idx);
  assign idx_nxt = pop ? '0 : idx_r + 3'd1;

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_byte   = out_last_byte_r;
  assign out_order_error = out_order_error_r;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r        <= mtee_pkg::event_byte(head.ev, idx_r);
      out_last_byte_r   <= pop;
      out_order_error_r <= head.ev.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= head.valid;
      end
      if (load) begin
        idx_r <= idx_nxt;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head.valid |-> idx_r <= head.ev.last_idx)
    else $error("byte index beyond the last byte of the head event");

  a_mid_event: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != '0 |-> head.valid)
    else $error("queue emptied part way through an event");

  a_meta_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    (load && head.ev.cmd != mtee_pkg::CMD_CHANNEL) |=> !out_order_error_r)
    else $error("order error raised on a meta event word");
`endif

endmodule

/* hdl/midi_track_event_encoder_core.sv */
// MIDI track event encoder, top level: front end, two-entry queue and byte back end.
// Events are written into the queue when accepted; the first byte of an event is registered
// from the queue head into the output register. Throughput: one byte per cycle while
// out_stall is low, and an event has four to eight bytes; the queue holds the event
// being emitted and one more, and the input stalls while both entries are taken.
// Reset is synchronous and active low; it clears the previous tick, queue and output valid.
module midi_track_event_encoder_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_command,
  input  logic [mtee_pkg::TICK_BITS-1:0] in_tick,
  input  logic [7:0]                     in_status_byte,
  input  logic [6:0]                     in_data_one,
  input  logic [6:0]                     in_data_two,
  input  logic [23:0]                    in_micros_per_quarter,
  input  logic [7:0]                     in_beats_per_bar,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_last_byte,
  output logic                           out_order_error
);

  mtee_pkg::event_t ev;
  mtee_pkg::head_t  head;
  logic             accept;
  logic             full;
  logic             pop;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  mtee_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .accept             (accept),
    .command            (in_command),
    .tick               (in_tick),
    .status_byte        (in_status_byte),
    .data_one           (in_data_one),
    .data_two           (in_data_two),
    .micros_per_quarter (in_micros_per_quarter),
    .beats_per_bar      (in_beats_per_bar),
    .ev                 (ev)
  );

  mtee_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (accept),
    .push_ev (ev),
    .pop     (pop),
    .head    (head),
    .full    (full)
  );

  mtee_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_byte   (out_last_byte),
    .out_order_error (out_order_error)
  );

endmodule
